// File: design/pcsd_pkg.sv
package pcsd_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int COORD_W = 23;

  // coordinate scale for the 's' and 'a' commands
  localparam logic [COORD_W-1:0] COORD_SCALE = COORD_W'(100);

  typedef struct packed {
    logic               item_kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } stage_t;

endpackage

// File: design/pcsd_stream_if.sv
interface pcsd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [pcsd_pkg::BYTE_W-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface pcsd_result_if;
  logic                         valid;
  logic                         ready;
  logic                         item_kind;
  logic [pcsd_pkg::COORD_W-1:0] start_x;
  logic [pcsd_pkg::COORD_W-1:0] start_y;
  logic [pcsd_pkg::COORD_W-1:0] end_x;
  logic [pcsd_pkg::COORD_W-1:0] end_y;

  modport source (output valid, output item_kind, output start_x, output start_y,
                  output end_x, output end_y, input ready);
  modport sink   (input valid, input item_kind, input start_x, input start_y,
                  input end_x, input end_y, output ready);
endinterface

// File: design/pcsd_in_stage.sv
module pcsd_in_stage (
  input  logic             clk,
  input  logic             rst,
  pcsd_byte_if.sink        in_ch,
  input  logic             advance,
  output pcsd_pkg::stage_t stage
);
  import pcsd_pkg::*;

  logic              valid;
  logic [BYTE_W-1:0] data;

  // take a new byte when empty or when the held one moves on this cycle
  assign in_ch.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      data <= in_ch.byte_in;
    end
  end

  assign stage = '{valid: valid, data: data};

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    valid && !advance |=> valid && $stable(data))
    else $error("held byte lost while stalled");

endmodule

// File: design/pcsd_decode.sv
module pcsd_decode (
  input  logic              clk,
  input  logic              rst,
  input  pcsd_pkg::stage_t  stage,
  input  logic              advance,
  output logic              res_fire,
  output pcsd_pkg::result_t res
);
  import pcsd_pkg::*;

  typedef enum logic [2:0] {
    CMD_IDLE, CMD_S, CMD_L, CMD_C, CMD_N, CMD_A, CMD_T
  } cmd_t;

  localparam logic [BYTE_W-1:0] CH_S = 8'h73;
  localparam logic [BYTE_W-1:0] CH_L = 8'h6C;
  localparam logic [BYTE_W-1:0] CH_C = 8'h63;
  localparam logic [BYTE_W-1:0] CH_N = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_A = 8'h61;
  localparam logic [BYTE_W-1:0] CH_T = 8'h74;

  cmd_t               cmd, cmd_next;
  logic [3:0]         byte_position, byte_position_next;
  logic [BYTE_W-1:0]  held_byte, held_byte_next;
  logic [WORD_W-1:0]  word_a, word_a_next;
  logic [WORD_W-1:0]  word_b, word_b_next;
  logic [WORD_W-1:0]  word_c, word_c_next;
  logic [COORD_W-1:0] last_end_x, last_end_x_next;
  logic [COORD_W-1:0] last_end_y, last_end_y_next;

  logic [BYTE_W-1:0]  b;
  logic [WORD_W-1:0]  w;
  logic [2:0]         idx;
  logic [COORD_W-1:0] scaled_c, scaled_w;
  logic               done;

  assign b   = stage.data;
  // 'a' words are big-endian, all others little-endian
  assign w   = (cmd == CMD_A) ? {held_byte, b} : {b, held_byte};
  assign idx = byte_position[3:1];
  assign scaled_c = COORD_W'(word_c) * COORD_SCALE;
  assign scaled_w = COORD_W'(w) * COORD_SCALE;

  always_comb begin
    cmd_next           = cmd;
    byte_position_next = byte_position;
    held_byte_next     = held_byte;
    word_a_next        = word_a;
    word_b_next        = word_b;
    word_c_next        = word_c;
    last_end_x_next    = last_end_x;
    last_end_y_next    = last_end_y;
    res_fire           = 1'b0;
    res                = '0;
    done               = 1'b0;

    if (cmd == CMD_IDLE) begin
      byte_position_next = '0;
      case (b)
        CH_S:    cmd_next = CMD_S;
        CH_L:    cmd_next = CMD_L;
        CH_C:    cmd_next = CMD_C;
        CH_N:    cmd_next = CMD_N;
        CH_A:    cmd_next = CMD_A;
        CH_T:    cmd_next = CMD_T;
        default: cmd_next = CMD_IDLE;
      endcase
    end else if (cmd == CMD_T) begin
      if (b == '0) begin
        cmd_next = CMD_IDLE;
      end
    end else if (!byte_position[0]) begin
      held_byte_next     = b;
      byte_position_next = byte_position + 4'd1;
    end else begin
      byte_position_next = byte_position + 4'd1;
      case (idx)
        3'd0:    word_a_next = w;
        3'd1:    word_b_next = w;
        3'd2:    word_c_next = w;
        default: ;
      endcase

      case (cmd)
        CMD_S: begin
          if (idx >= 3'd3) begin
            last_end_x_next = scaled_c;
            last_end_y_next = scaled_w;
            done            = 1'b1;
          end
        end
        CMD_L: begin
          if (idx >= 3'd3) begin
            res_fire        = 1'b1;
            res             = '{1'b0, COORD_W'(word_a), COORD_W'(word_b),
                                COORD_W'(word_c), COORD_W'(w)};
            last_end_x_next = COORD_W'(word_c);
            last_end_y_next = COORD_W'(w);
            done            = 1'b1;
          end
        end
        CMD_C: begin
          if (idx >= 3'd2) begin
            res_fire = 1'b1;
            res      = '{1'b1, COORD_W'(word_a), COORD_W'(word_b), '0, '0};
            done     = 1'b1;
          end
        end
        CMD_N: begin
          if (idx >= 3'd1) begin
            res_fire        = 1'b1;
            res             = '{1'b0, COORD_W'(word_a), COORD_W'(w),
                                last_end_x, last_end_y};
            last_end_x_next = COORD_W'(word_a);
            last_end_y_next = COORD_W'(w);
            done            = 1'b1;
          end
        end
        CMD_A: begin
          // end point taken from the fourth word, the fifth closes the command
          if (idx == 3'd3) begin
            last_end_x_next = scaled_c;
            last_end_y_next = scaled_w;
          end else if (idx >= 3'd4) begin
            done = 1'b1;
          end
        end
        default: done = 1'b1;
      endcase

      if (done) begin
        cmd_next           = CMD_IDLE;
        byte_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd           <= CMD_IDLE;
      byte_position <= '0;
      held_byte     <= '0;
      word_a        <= '0;
      word_b        <= '0;
      word_c        <= '0;
      last_end_x    <= '0;
      last_end_y    <= '0;
    end else if (advance) begin
      cmd           <= cmd_next;
      byte_position <= byte_position_next;
      held_byte     <= held_byte_next;
      word_a        <= word_a_next;
      word_b        <= word_b_next;
      word_c        <= word_c_next;
      last_end_x    <= last_end_x_next;
      last_end_y    <= last_end_y_next;
    end
  end

  a_idle_pos_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd == CMD_IDLE || cmd == CMD_T) |-> byte_position == '0)
    else $error("byte position nonzero outside a coordinate command");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= 4'd9)
    else $error("byte position past longest command");

  a_fire_cmd: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> (cmd == CMD_L || cmd == CMD_C || cmd == CMD_N))
    else $error("result from a command that gives none");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res_fire |=> cmd == CMD_IDLE)
    else $error("command not closed after its result");

endmodule

// File: design/pcsd_out_stage.sv
module pcsd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  pcsd_pkg::result_t res,
  output logic              free,
  pcsd_result_if.source     out_ch
);
  import pcsd_pkg::*;

  logic    valid;
  result_t data;

  assign free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
    if (load) begin
      data <= res;
    end
  end

  assign out_ch.valid     = valid;
  assign out_ch.item_kind = data.item_kind;
  assign out_ch.start_x   = data.start_x;
  assign out_ch.start_y   = data.start_y;
  assign out_ch.end_x     = data.end_x;
  assign out_ch.end_y     = data.end_y;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("result register overwritten before taken");

endmodule

// File: design/plot_command_stream_decoder.sv
// Channel   Dir  Payload                                     Handshake
// in_ch     in   byte_in[7:0]                                valid/ready
// out_ch    out  item_kind, start_x, start_y, end_x, end_y   valid/ready
//
// One byte per cycle while no full result register stalls it: a byte is held in
// the input register, is decoded against the command state, and a line or via
// is then registered in the result register.
// Reset (rst, synchronous) returns the decoder to waiting for a command byte
// with the remembered end point at the origin; both stage registers empty.
// A full result register stalls only bytes that would produce a result; data
// bytes and ignored bytes keep flowing while the result waits.
module plot_command_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  pcsd_byte_if.sink     in_ch,
  pcsd_result_if.source out_ch
);
  import pcsd_pkg::*;

  stage_t  stage;     // input register contents
  result_t res;       // decoded result, combinational
  logic    res_fire;  // held byte closes a line or via command
  logic    out_free;  // result register can take a new item
  logic    advance;   // held byte is consumed this cycle

  // A byte moves on unless it would produce a result into a busy register.
  assign advance = stage.valid && (out_free || !res_fire);

  pcsd_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // command state, word assembly and the remembered end point
  pcsd_decode u_dec (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .advance  (advance),
    .res_fire (res_fire),
    .res      (res)
  );

  pcsd_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && res_fire),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
